// ===== src/ed_pkg.sv =====
// Shared types and constants of the edit distance engine.
package ed_pkg;

  localparam int unsigned CH_W   = 8;
  localparam int unsigned DIST_W = 7;
  localparam logic [DIST_W-1:0] DIST_MAX = 7'd127;

  // Codes of the func field.
  localparam logic FUNC_FIRST  = 1'b0;
  localparam logic FUNC_SECOND = 1'b1;

  // Control of the cell update unit.
  typedef struct packed {
    logic row_start;
    logic step;
    logic first_row;
  } cell_ctrl_t;

endpackage

// ===== src/ed_cell.sv =====
// Cell update unit: keeps the left and diagonal costs of the current row.
module ed_cell #(
  parameter int unsigned LW = 7
) (
  input  logic                    clk,
  input  ed_pkg::cell_ctrl_t      ctrl,
  input  logic [LW-1:0]           row_i,
  input  logic [LW-1:0]           col_j,
  input  logic [ed_pkg::CH_W-1:0] ch_a,
  input  logic [ed_pkg::CH_W-1:0] ch_b,
  input  logic [LW-1:0]           above_mem,
  output logic [LW-1:0]           cell_val
);
  import ed_pkg::*;

  logic [LW-1:0] left_r;
  logic [LW-1:0] diag_r;
  logic [LW-1:0] above;
  logic [LW:0]   sub_cost;
  logic [LW:0]   del_cost;
  logic [LW:0]   ins_cost;
  logic [LW:0]   min_ab;
  logic [LW:0]   min_all;

  // The first row reads the border values j instead of the cost memory.
  assign above    = ctrl.first_row ? col_j : above_mem;
  assign sub_cost = {1'b0, diag_r} + (LW+1)'(ch_a != ch_b);
  assign del_cost = {1'b0, above} + (LW+1)'(1);
  assign ins_cost = {1'b0, left_r} + (LW+1)'(1);
  assign min_ab   = (sub_cost < del_cost) ? sub_cost : del_cost;
  assign min_all  = (min_ab < ins_cost) ? min_ab : ins_cost;
  // A cell never exceeds the longer string length, so the top bit is zero.
  assign cell_val = min_all[LW-1:0];

  always_ff @(posedge clk) begin
    if (ctrl.row_start) begin
      left_r <= row_i;
      diag_r <= row_i - LW'(1);
    end else if (ctrl.step) begin
      left_r <= cell_val;
      diag_r <= above;
    end
  end

endmodule

// ===== src/edit_distance_engine.sv =====
// Levenshtein edit distance engine: top level with string and cost memories.
// Words on the input channel append one character to the first string
// (func = 0) or the second string (func = 1); characters beyond MAX_LEN are
// dropped and flagged in too_long. A word that appends to the first string,
// or to the second without last, leaves the input ready. The word that closes
// the second string starts the computation: with lengths L1 and L2 both
// nonzero it computes one row of the cost matrix per pass through the cost
// memory, one cell per cycle, after reading the first string's character and
// priming the second string and cost reads for each row; with an empty string
// it goes straight to the result. The input is held off during that time. The
// result word sits in an output register, so a new string pair can be loaded
// while it waits; both strings are empty again once the result is registered.
// Distances above 127 saturate.
module edit_distance_engine #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_func,
  input  logic [ed_pkg::CH_W-1:0]   in_ch,
  input  logic                      in_last,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ed_pkg::DIST_W-1:0] out_distance,
  output logic                      out_too_long
);
  import ed_pkg::*;

  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned SW = (LW > DIST_W) ? LW : DIST_W;

  typedef enum logic [1:0] {S_IDLE, S_ROW, S_SWEEP, S_DONE} state_t;

  state_t        state_r;
  logic [LW-1:0] len1_r;
  logic [LW-1:0] len2_r;
  logic          ovf_r;
  logic [LW-1:0] i_r;
  logic [AW-1:0] j_rd_r;
  logic          iss_r;
  logic          p_v_r;
  logic [AW-1:0] p_idx_r;
  logic [LW-1:0] res_r;
  logic          out_valid_r;
  logic [DIST_W-1:0] out_distance_r;
  logic          out_too_long_r;

  logic [CH_W-1:0] str_a_mem [MAX_LEN];
  logic [CH_W-1:0] str_b_mem [MAX_LEN];
  logic [LW-1:0]   cost_mem  [MAX_LEN];
  logic [CH_W-1:0] a_rd_r;
  logic [CH_W-1:0] b_rd_r;
  logic [LW-1:0]   c_rd_r;

  logic          accept;
  logic          a_wr_en;
  logic          b_wr_en;
  logic          a_rd_en;
  logic          bc_rd_en;
  logic          c_wr_en;
  logic          close_item;
  logic          row_last;
  logic          iss_last;
  logic [LW-1:0] col_j;
  logic [LW-1:0] cell_val;
  logic [SW-1:0] res_wide;
  logic [DIST_W-1:0] res_sat;
  cell_ctrl_t    cell_ctrl;

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;
  assign out_too_long = out_too_long_r;

  assign accept     = in_valid && in_ready;
  assign close_item = accept && (in_func == FUNC_SECOND) && in_last;
  assign a_wr_en    = accept && (in_func == FUNC_FIRST) && (len1_r < LW'(MAX_LEN));
  assign b_wr_en    = accept && (in_func == FUNC_SECOND) && (len2_r < LW'(MAX_LEN));

  assign a_rd_en  = (state_r == S_ROW);
  assign bc_rd_en = (state_r == S_SWEEP) && iss_r;
  assign c_wr_en  = (state_r == S_SWEEP) && p_v_r;
  assign iss_last = (LW'(j_rd_r) + LW'(1)) == len2_r;
  assign row_last = (LW'(p_idx_r) + LW'(1)) == len2_r;
  assign col_j    = LW'(p_idx_r) + LW'(1);

  assign cell_ctrl.row_start = (state_r == S_ROW);
  assign cell_ctrl.step      = c_wr_en;
  assign cell_ctrl.first_row = (i_r == LW'(1));

  assign res_wide = SW'(res_r);
  assign res_sat  = (res_wide > SW'(DIST_MAX)) ? DIST_MAX : res_wide[DIST_W-1:0];

  ed_cell #(.LW(LW)) u_cell (
    .clk       (clk),
    .ctrl      (cell_ctrl),
    .row_i     (i_r),
    .col_j     (col_j),
    .ch_a      (a_rd_r),
    .ch_b      (b_rd_r),
    .above_mem (c_rd_r),
    .cell_val  (cell_val)
  );

  always_ff @(posedge clk) begin
    if (a_wr_en) begin
      str_a_mem[len1_r[AW-1:0]] <= in_ch;
    end
    if (a_rd_en) begin
      a_rd_r <= str_a_mem[i_r[AW-1:0] - AW'(1)];
    end
  end

  always_ff @(posedge clk) begin
    if (b_wr_en) begin
      str_b_mem[len2_r[AW-1:0]] <= in_ch;
    end
    if (bc_rd_en) begin
      b_rd_r <= str_b_mem[j_rd_r];
    end
  end

  // Reads run one column ahead of the write, so they never meet the same entry.
  always_ff @(posedge clk) begin
    if (c_wr_en) begin
      cost_mem[p_idx_r] <= cell_val;
    end
    if (bc_rd_en) begin
      c_rd_r <= cost_mem[j_rd_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len1_r      <= '0;
      len2_r      <= '0;
      ovf_r       <= 1'b0;
      i_r         <= '0;
      j_rd_r      <= '0;
      iss_r       <= 1'b0;
      p_v_r       <= 1'b0;
      p_idx_r     <= '0;
      res_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // In S_DONE the output register is handled by the state itself.
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (a_wr_en) begin
            len1_r <= len1_r + LW'(1);
          end
          if (b_wr_en) begin
            len2_r <= len2_r + LW'(1);
          end
          if (accept && !a_wr_en && !b_wr_en) begin
            ovf_r <= 1'b1;
          end
          if (close_item) begin
            i_r     <= LW'(1);
            state_r <= S_ROW;
          end
        end
        S_ROW: begin
          j_rd_r <= '0;
          p_v_r  <= 1'b0;
          if (len1_r == '0 || len2_r == '0) begin
            res_r   <= len1_r | len2_r;
            state_r <= S_DONE;
          end else begin
            iss_r   <= 1'b1;
            state_r <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          p_v_r   <= iss_r;
          p_idx_r <= j_rd_r;
          if (iss_r) begin
            if (iss_last) begin
              iss_r <= 1'b0;
            end else begin
              j_rd_r <= j_rd_r + AW'(1);
            end
          end
          if (p_v_r && row_last) begin
            if (i_r == len1_r) begin
              res_r   <= cell_val;
              state_r <= S_DONE;
            end else begin
              i_r     <= i_r + LW'(1);
              state_r <= S_ROW;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r    <= 1'b1;
            out_distance_r <= res_sat;
            out_too_long_r <= ovf_r;
            len1_r         <= '0;
            len2_r         <= '0;
            ovf_r          <= 1'b0;
            state_r        <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/ed_checker.sv =====
// Port-level checks of the edit distance engine and their binding.
module ed_checker #(
  parameter int unsigned MAX_LEN = 64
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      in_func,
  input logic                      in_last,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [ed_pkg::DIST_W-1:0] out_distance,
  input logic                      out_too_long
);
  import ed_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // A stalled result word keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distance) && $stable(out_too_long))
    else $error("result word changed while stalled");

  // Closing the second string starts a computation that holds off input.
  a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_func == FUNC_SECOND) && in_last |=> !in_ready)
    else $error("input taken right after the closing word");

  // Any other word is absorbed without holding off the input.
  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !((in_func == FUNC_SECOND) && in_last) |=> in_ready)
    else $error("block busy after a plain load word");

  // The distance cannot exceed the longest storable string.
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_distance) <= MAX_LEN))
    else $error("distance above string capacity");

endmodule

bind edit_distance_engine ed_checker #(.MAX_LEN(MAX_LEN)) u_ed_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_func      (in_func),
  .in_last      (in_last),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_distance (out_distance),
  .out_too_long (out_too_long)
);
